>>> design/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Real checks in simulation, empty bodies when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge out of reset
`define HTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// cond must never be true out of reset
`define HTS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define HTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HTS_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> design/hts_pkg.sv
// Types and fixed constants of the Huffman tree stream decoder.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package hts_pkg;

    localparam int SYM_W = 8;
    localparam int IDX_W = 9;
    localparam logic [3:0] BYTE_BITS = 4'd8;
    localparam logic [3:0] LEAF_BITS = 4'd8;

    // one node table entry: leaf flag, right child, symbol
    typedef struct packed {
        logic             leaf;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] sym;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_HALT   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_BIT,
        SQ_POP,
        SQ_RESOLVE,
        SQ_DONE
    } t_seq;

endpackage

`default_nettype wire

>>> design/hts_if.sv
// Valid/ready channel interfaces: encoded bytes in, decoded results out.
// Depends on hts_pkg for the field widths.
`default_nettype none

interface hts_in_if import hts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] data_byte;
    logic             new_stream;

    modport source (output valid, output data_byte, output new_stream, input ready);
    modport sink (input valid, input data_byte, input new_stream, output ready);
endinterface

interface hts_out_if import hts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             error;
    logic             last_of_run;

    modport source (output valid, output symbol, output error, output last_of_run,
                    input ready);
    modport sink (input valid, input symbol, input error, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

>>> design/hts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the node table and the pending stack.
`default_nettype none

module hts_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/huffman_tree_stream_decoder.sv
// Huffman stream decoder, preorder tree header; bytes shift out one bit per cycle unless stalled or popping.
// Data byte: 8 tree steps, then a resolve step and a flush step that can accept the next byte;
// each tree step is one node table read, the RAM output feeding the next read address.
// Header byte: a step per bit plus a pop step per leaf that closes a pending node; stops early at tree end or on error.
// The last result of a byte is loaded into the output register by its flush step.
// Reset (synchronous, active low) clears control state only; memories are not cleared.
`default_nettype none
`include "assert_macros.svh"

module huffman_tree_stream_decoder import hts_pkg::*; #(
    parameter int MAX_NODES   = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hts_in_if.sink     i_in,
    hts_out_if.source  o_out
);

    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int SLVL_W  = $clog2(STACK_DEPTH + 1);

    // out-of-table index maps to entry 0
    function automatic logic [NODE_AW-1:0] f_tidx(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] wide;
        wide = {1'b0, idx};
        return (wide < (IDX_W+1)'(MAX_NODES)) ? NODE_AW'(idx) : '0;
    endfunction

    t_seq              r_seq, n_seq;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_byte, n_byte;
    logic [3:0]        r_nbits, n_nbits;
    logic [3:0]        r_leaf_left, n_leaf_left;
    logic [SYM_W-1:0]  r_leaf_shift, n_leaf_shift;
    logic [NCNT_W-1:0] r_node_count, n_node_count;
    logic [SLVL_W-1:0] r_stack_level, n_stack_level;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic              r_src_ram, n_src_ram;
    logic [IDX_W-1:0]  r_root_right, n_root_right;
    logic              r_held_valid, n_held_valid;
    logic [SYM_W-1:0]  r_held_sym, n_held_sym;
    logic              r_held_err, n_held_err;
    logic              r_out_valid, n_out_valid;
    logic [SYM_W-1:0]  r_out_sym, n_out_sym;
    logic              r_out_err, n_out_err;
    logic              r_out_last, n_out_last;

    logic               node_we, node_re;
    logic [NODE_AW-1:0] node_waddr, node_raddr;
    t_entry             node_wdata;
    logic [ENTRY_W-1:0] node_rdata;
    t_entry             entry_q;
    logic               stk_we, stk_re;
    logic [STK_AW-1:0]  stk_waddr, stk_raddr;
    logic [IDX_W-1:0]   stk_wdata, stk_rdata;

    logic              bit_in, out_free, in_acc, acc_go, last_bit;
    logic              cur_is_leaf, push_req, stall;
    logic              hd_leaf_busy, hd_leaf_done, hd_tree_done, hd_single, hd_pop;
    logic              hd_node_ovf, hd_stk_ovf, hd_err;
    logic [SYM_W-1:0]  shift_nx;
    logic [NCNT_W-1:0] nc_m1;
    logic [SLVL_W-1:0] lvl_m1;
    logic [IDX_W-1:0]  right_eff, cur_eff, next_node;
    logic [NODE_AW-1:0] pop_addr;

    hts_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    hts_ram #(.WIDTH(IDX_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // shared decode
    assign entry_q     = t_entry'(node_rdata);
    assign bit_in      = r_byte[7];
    assign last_bit    = (r_nbits == 4'd1);
    assign out_free    = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign acc_go      = in_acc && (i_in.new_stream || r_phase == PH_HEADER
                                    || r_phase == PH_DATA);
    assign cur_is_leaf = r_src_ram && entry_q.leaf;

    assign hd_leaf_busy = (r_leaf_left != 4'd0);
    assign hd_leaf_done = (r_leaf_left == 4'd1);
    assign hd_tree_done = hd_leaf_done && (r_stack_level == '0);
    assign hd_single    = hd_tree_done && (r_node_count == NCNT_W'(1));
    assign hd_pop       = hd_leaf_done && (r_stack_level != '0);
    assign hd_node_ovf  = !hd_leaf_busy && (r_node_count >= NCNT_W'(MAX_NODES));
    assign hd_stk_ovf   = !hd_leaf_busy && !hd_node_ovf && !bit_in
                          && (r_stack_level >= SLVL_W'(STACK_DEPTH));
    assign hd_err       = hd_single || hd_node_ovf || hd_stk_ovf;
    assign shift_nx     = {r_leaf_shift[SYM_W-2:0], bit_in};
    assign nc_m1        = r_node_count - NCNT_W'(1);
    assign lvl_m1       = r_stack_level - SLVL_W'(1);
    assign pop_addr     = f_tidx(stk_rdata);

    // tree walk: a leaf read by the previous step sends this step back to the root
    assign right_eff = (r_src_ram && !entry_q.leaf) ? entry_q.right : r_root_right;
    assign cur_eff   = (r_src_ram && !entry_q.leaf) ? r_cur : '0;
    assign next_node = bit_in ? right_eff : (cur_eff + IDX_W'(1));

    assign push_req = ((r_seq == SQ_BIT) && (r_phase == PH_DATA) && cur_is_leaf
                       && r_held_valid)
                   || ((r_seq == SQ_RESOLVE) && cur_is_leaf && r_held_valid)
                   || ((r_seq == SQ_DONE) && r_held_valid);
    assign stall    = push_req && !out_free;

    assign i_in.ready = (r_seq == SQ_IDLE) || ((r_seq == SQ_DONE) && !stall);

    assign o_out.valid       = r_out_valid;
    assign o_out.symbol      = r_out_sym;
    assign o_out.error       = r_out_err;
    assign o_out.last_of_run = r_out_last;

    // next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: begin
                if (acc_go) begin
                    n_seq = SQ_BIT;
                end
            end
            SQ_BIT: begin
                if (!stall) begin
                    priority if (r_phase == PH_HEADER) begin
                        priority if (hd_err || hd_tree_done) begin
                            n_seq = SQ_DONE;
                        end else if (hd_pop) begin
                            n_seq = SQ_POP;
                        end else if (last_bit) begin
                            n_seq = SQ_DONE;
                        end else begin
                            n_seq = SQ_BIT;
                        end
                    end else if (r_phase == PH_DATA) begin
                        n_seq = last_bit ? SQ_RESOLVE : SQ_BIT;
                    end else begin
                        n_seq = SQ_DONE;
                    end
                end
            end
            SQ_POP: begin
                n_seq = (r_nbits == 4'd0) ? SQ_DONE : SQ_BIT;
            end
            SQ_RESOLVE: begin
                if (!stall) begin
                    n_seq = SQ_DONE;
                end
            end
            SQ_DONE: begin
                if (!stall) begin
                    n_seq = acc_go ? SQ_BIT : SQ_IDLE;
                end
            end
            default: n_seq = SQ_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_phase       = r_phase;
        n_byte        = r_byte;
        n_nbits       = r_nbits;
        n_leaf_left   = r_leaf_left;
        n_leaf_shift  = r_leaf_shift;
        n_node_count  = r_node_count;
        n_stack_level = r_stack_level;
        n_cur         = r_cur;
        n_src_ram     = r_src_ram;
        n_root_right  = r_root_right;
        n_held_valid  = r_held_valid;
        n_held_sym    = r_held_sym;
        n_held_err    = r_held_err;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_sym     = r_out_sym;
        n_out_err     = r_out_err;
        n_out_last    = r_out_last;
        node_we       = 1'b0;
        node_waddr    = '0;
        node_wdata    = '0;
        node_re       = 1'b0;
        node_raddr    = '0;
        stk_we        = 1'b0;
        stk_waddr     = '0;
        stk_wdata     = '0;
        stk_re        = 1'b0;
        stk_raddr     = '0;

        if (!stall) begin
            unique case (r_seq)
                SQ_IDLE, SQ_DONE: begin
                    if ((r_seq == SQ_DONE) && r_held_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_sym    = r_held_sym;
                        n_out_err    = r_held_err;
                        n_out_last   = 1'b1;
                        n_held_valid = 1'b0;
                    end
                    if (in_acc) begin
                        n_byte  = i_in.data_byte;
                        n_nbits = BYTE_BITS;
                        if (i_in.new_stream) begin
                            // restart: an unfinished code is dropped
                            n_phase       = PH_HEADER;
                            n_stack_level = '0;
                            n_node_count  = '0;
                            n_leaf_left   = '0;
                            n_leaf_shift  = '0;
                            n_cur         = '0;
                            n_src_ram     = 1'b0;
                        end
                    end
                end
                SQ_BIT: begin
                    n_byte  = {r_byte[6:0], 1'b0};
                    n_nbits = r_nbits - 4'd1;
                    priority if (r_phase == PH_HEADER) begin
                        if (hd_leaf_busy) begin
                            n_leaf_shift = shift_nx;
                            n_leaf_left  = r_leaf_left - 4'd1;
                            if (hd_leaf_done) begin
                                node_we         = 1'b1;
                                node_waddr      = f_tidx(IDX_W'(nc_m1));
                                node_wdata.leaf = 1'b1;
                                node_wdata.sym  = shift_nx;
                                if (hd_tree_done && !hd_single) begin
                                    n_phase   = PH_DATA;
                                    n_cur     = '0;
                                    n_src_ram = 1'b0;
                                end else if (hd_pop) begin
                                    // fetch the node that gets this right child
                                    n_stack_level = lvl_m1;
                                    stk_re        = 1'b1;
                                    stk_raddr     = STK_AW'(lvl_m1);
                                end
                            end
                        end else if (!hd_node_ovf) begin
                            if (bit_in) begin
                                n_node_count = r_node_count + NCNT_W'(1);
                                n_leaf_left  = LEAF_BITS;
                                n_leaf_shift = '0;
                            end else if (!hd_stk_ovf) begin
                                node_we       = 1'b1;
                                node_waddr    = f_tidx(IDX_W'(r_node_count));
                                stk_we        = 1'b1;
                                stk_waddr     = STK_AW'(r_stack_level);
                                stk_wdata     = IDX_W'(r_node_count);
                                n_stack_level = r_stack_level + SLVL_W'(1);
                                n_node_count  = r_node_count + NCNT_W'(1);
                                if (r_node_count == '0) begin
                                    n_root_right = '0;
                                end
                            end
                        end
                        if (hd_err) begin
                            n_phase      = PH_HALT;
                            n_held_valid = 1'b1;
                            n_held_sym   = '0;
                            n_held_err   = 1'b1;
                        end
                    end else if (r_phase == PH_DATA) begin
                        if (cur_is_leaf) begin
                            if (r_held_valid) begin
                                n_out_valid = 1'b1;
                                n_out_sym   = r_held_sym;
                                n_out_err   = r_held_err;
                                n_out_last  = 1'b0;
                            end
                            n_held_valid = 1'b1;
                            n_held_sym   = entry_q.sym;
                            n_held_err   = 1'b0;
                        end
                        node_re    = 1'b1;
                        node_raddr = f_tidx(next_node);
                        n_cur      = next_node;
                        n_src_ram  = 1'b1;
                    end else begin
                        n_nbits = r_nbits;
                    end
                end
                SQ_POP: begin
                    node_we          = 1'b1;
                    node_waddr       = pop_addr;
                    node_wdata.right = IDX_W'(r_node_count);
                    if (pop_addr == '0) begin
                        n_root_right = IDX_W'(r_node_count);
                    end
                end
                SQ_RESOLVE: begin
                    // the last step of the byte may have landed on a leaf
                    if (cur_is_leaf) begin
                        if (r_held_valid) begin
                            n_out_valid = 1'b1;
                            n_out_sym   = r_held_sym;
                            n_out_err   = r_held_err;
                            n_out_last  = 1'b0;
                        end
                        n_held_valid = 1'b1;
                        n_held_sym   = entry_q.sym;
                        n_held_err   = 1'b0;
                        n_cur        = '0;
                        n_src_ram    = 1'b0;
                    end
                end
                default: begin
                    n_held_valid = r_held_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= SQ_IDLE;
            r_phase       <= PH_HEADER;
            r_nbits       <= '0;
            r_leaf_left   <= '0;
            r_leaf_shift  <= '0;
            r_node_count  <= '0;
            r_stack_level <= '0;
            r_cur         <= '0;
            r_src_ram     <= 1'b0;
            r_held_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_seq         <= n_seq;
            r_phase       <= n_phase;
            r_nbits       <= n_nbits;
            r_leaf_left   <= n_leaf_left;
            r_leaf_shift  <= n_leaf_shift;
            r_node_count  <= n_node_count;
            r_stack_level <= n_stack_level;
            r_cur         <= n_cur;
            r_src_ram     <= n_src_ram;
            r_held_valid  <= n_held_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_root_right <= n_root_right;
        r_held_sym   <= n_held_sym;
        r_held_err   <= n_held_err;
        r_out_sym    <= n_out_sym;
        r_out_err    <= n_out_err;
        r_out_last   <= n_out_last;
    end

    `HTS_ASSERT(a_pop_resumes, i_clk, i_rst_n, r_seq == SQ_POP |=> (r_seq == SQ_BIT || r_seq == SQ_DONE), "pop cycle not followed by bit or flush")
    `HTS_NEVER(a_count_bounds, i_clk, i_rst_n, (r_node_count > NCNT_W'(MAX_NODES)) || (r_stack_level > SLVL_W'(STACK_DEPTH)), "node count or stack level out of range")
    `HTS_ASSERT(a_header_at_root, i_clk, i_rst_n, r_phase == PH_HEADER |-> !r_src_ram, "tree walk active during header parse")
    `HTS_ASSERT(a_error_halts, i_clk, i_rst_n, (r_held_valid && r_held_err) |-> r_phase == PH_HALT, "pending error result without halt")
    `HTS_ASSERT(a_error_zero_sym, i_clk, i_rst_n, (o_out.valid && o_out.error) |-> o_out.symbol == '0, "error result carries a symbol")

endmodule

`default_nettype wire

>>> tb/tb_huffman_tree_stream_decoder.sv
// Self-checking bench for the Huffman tree stream decoder: byte requests in, symbols out.
// Depends on hts_pkg and the hts_in_if / hts_out_if channel interfaces of the design.
// A tree walker predicts non-canned results; directed rows, a stack overflow run, random streams.
`default_nettype none

module tb_huffman_tree_stream_decoder import hts_pkg::*; ();

    localparam int N_NODES      = 512;
    localparam int N_STACK      = 256;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 38;
    localparam int RANDOM_BYTES = 45;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIRECTED   = 22;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             error;
        logic             last_of_run;
    } t_result;

    // one byte request; canned rows carry their expectation (at most one result)
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             new_stream;
        logic             canned;
        logic             has_res;
        logic [SYM_W-1:0] c_sym;
        logic             c_err;
    } t_request;

    typedef enum logic [1:0] {
        HDR_MORE,
        HDR_DONE,
        HDR_FAIL
    } t_hdr_step;

    logic i_clk;
    logic i_rst_n;

    hts_in_if  in_if ();
    hts_out_if out_if ();

    huffman_tree_stream_decoder #(
        .MAX_NODES   (N_NODES),
        .STACK_DEPTH (N_STACK)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // tree walker state
    t_entry           tree_nodes [N_NODES];
    logic [IDX_W-1:0] pending_nodes [N_STACK];
    logic [8:0]       pending_level;
    logic [9:0]       nodes_built;
    t_phase           walk_phase;
    logic [3:0]       sym_bits_left;
    logic [7:0]       sym_shift;
    logic [IDX_W-1:0] walk_node;

    t_result  expected_syms [$];
    t_result  byte_syms [$];
    logic     stream_bits [$];
    t_request directed_rows [N_DIRECTED];

    int fails;
    int checked;
    int errors_seen;
    int sent_bytes;
    int halted_bytes;
    int streams;
    int cycles;
    bit steady;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int node_at(int i);
        return (i >= 0 && i < N_NODES) ? i : 0;
    endfunction

    function automatic int level_at(int i);
        return (i >= 0 && i < N_STACK) ? i : 0;
    endfunction

    function automatic void restart_tree();
        pending_level = '0;
        nodes_built   = '0;
        walk_phase    = PH_HEADER;
        sym_bits_left = '0;
        sym_shift     = '0;
        walk_node     = '0;
    endfunction

    // consume one header bit while rebuilding the preorder tree
    function automatic t_hdr_step tree_header_bit(logic b);
        logic [IDX_W-1:0] parent;
        if (sym_bits_left != 0) begin
            sym_shift     = {sym_shift[6:0], b};
            sym_bits_left = sym_bits_left - 1'b1;
            if (sym_bits_left != 0)
                return HDR_MORE;
            tree_nodes[node_at(nodes_built - 1)] = '{leaf: 1'b1, right: '0, sym: sym_shift};
            if (pending_level == 0)
                return (nodes_built == 1) ? HDR_FAIL : HDR_DONE;
            // close the most recently opened internal node: its right child starts here
            pending_level = pending_level - 1'b1;
            parent = pending_nodes[level_at(pending_level)];
            tree_nodes[node_at(parent)].right = nodes_built[IDX_W-1:0];
            return HDR_MORE;
        end
        if (nodes_built >= N_NODES)
            return HDR_FAIL;
        if (b) begin
            nodes_built   = nodes_built + 1'b1;
            sym_bits_left = LEAF_BITS;
            sym_shift     = '0;
        end else begin
            if (pending_level >= N_STACK)
                return HDR_FAIL;
            tree_nodes[node_at(nodes_built)] = '0;
            pending_nodes[level_at(pending_level)] = nodes_built[IDX_W-1:0];
            pending_level = pending_level + 1'b1;
            nodes_built   = nodes_built + 1'b1;
        end
        return HDR_MORE;
    endfunction

    // work out the symbols one byte request yields; fills byte_syms
    function automatic void decode_byte(logic [7:0] b, logic ns);
        logic [IDX_W-1:0] nxt;
        t_entry           ent;
        t_result          r;
        t_hdr_step        st;
        bit               stop;
        byte_syms.delete();
        if (ns)
            restart_tree();
        if (walk_phase != PH_HEADER && walk_phase != PH_DATA)
            halted_bytes++;
        stop = 1'b0;
        for (int k = 7; k >= 0 && !stop; k--) begin
            case (walk_phase)
                PH_HEADER: begin
                    st = tree_header_bit(b[k]);
                    if (st == HDR_DONE) begin
                        // skip the rest of the byte, walk from the root
                        walk_phase = PH_DATA;
                        walk_node  = '0;
                        stop       = 1'b1;
                    end else if (st == HDR_FAIL) begin
                        walk_phase = PH_HALT;
                        byte_syms.push_back('{symbol: '0, error: 1'b1, last_of_run: 1'b0});
                        stop = 1'b1;
                    end
                end
                PH_DATA: begin
                    nxt = b[k] ? tree_nodes[node_at(walk_node)].right : walk_node + 1'b1;
                    ent = tree_nodes[node_at(nxt)];
                    if (ent.leaf) begin
                        byte_syms.push_back('{symbol: ent.sym, error: 1'b0, last_of_run: 1'b0});
                        walk_node = '0;
                    end else begin
                        walk_node = nxt;
                    end
                end
                default: stop = 1'b1;
            endcase
        end
        if (byte_syms.size() > 0) begin
            r = byte_syms.pop_back();
            r.last_of_run = 1'b1;
            byte_syms.push_back(r);
        end
    endfunction

    function automatic void push_leaf(logic [7:0] s);
        stream_bits.push_back(1'b1);
        for (int k = 7; k >= 0; k--)
            stream_bits.push_back(s[k]);
    endfunction

    // append a random preorder subtree; the root is always internal
    function automatic void add_subtree(int lvl, int max_lvl);
        if (lvl == 0 || (lvl < max_lvl && stream_bits.size() < 1500
                         && $urandom_range(0, 99) < 55)) begin
            stream_bits.push_back(1'b0);
            add_subtree(lvl + 1, max_lvl);
            add_subtree(lvl + 1, max_lvl);
        end else begin
            push_leaf(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_item(t_request req);
        t_result fx;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= req.data_byte;
        in_if.new_stream <= req.new_stream;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sent_bytes++;
        if (req.new_stream)
            streams++;
        decode_byte(req.data_byte, req.new_stream);
        if (req.canned) begin
            if (req.has_res) begin
                fx = '{symbol: req.c_sym, error: req.c_err, last_of_run: 1'b1};
                expected_syms.push_back(fx);
            end
        end else begin
            foreach (byte_syms[j])
                expected_syms.push_back(byte_syms[j]);
        end
    endtask

    task automatic send_plain(logic [7:0] b, logic ns);
        send_item({b, ns, 11'b0});
    endtask

    // pad the bit stream with random bits to whole bytes and send it
    task automatic send_bits(logic first_ns);
        logic [7:0] acc;
        logic       ns_now;
        while (stream_bits.size() % 8 != 0)
            stream_bits.push_back(1'($urandom_range(0, 1)));
        ns_now = first_ns;
        while (stream_bits.size() > 0) begin
            for (int k = 7; k >= 0; k--)
                acc[k] = stream_bits.pop_front();
            send_plain(acc, ns_now);
            ns_now = 1'b0;
        end
    endtask

    // drop valid and hold until every pending result has drained
    task automatic hold_off();
        in_if.valid <= 1'b0;
        while (expected_syms.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_syms.size() == 0) begin
                $error("unexpected result: symbol %h error %b last_of_run %b",
                       out_if.symbol, out_if.error, out_if.last_of_run);
                fails++;
            end else begin
                want = expected_syms.pop_front();
                checked++;
                if (out_if.error === 1'b1)
                    errors_seen++;
                if (out_if.symbol !== want.symbol) begin
                    $error("symbol: expected %h, got %h", want.symbol, out_if.symbol);
                    fails++;
                end
                if (out_if.error !== want.error) begin
                    $error("error: expected %b, got %b", want.error, out_if.error);
                    fails++;
                end
                if (out_if.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, out_if.last_of_run);
                    fails++;
                end
            end
        end
        out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, expected_syms.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int base;
        int kind;
        int cut;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= '0;
        in_if.new_stream <= 1'b0;
        i_rst_n          <= 1'b0;
        steady = 1'b0;

        // data, new_stream, canned, has_res, symbol, error
        directed_rows = '{
            {8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},  // out of reset: leaf, 7 symbol bits
            {8'hFF, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1},  // lone leaf closes the tree
            {8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},  // halted: ignore
            {8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
            {8'h40, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},  // two leaves, 0x00 and 0xFF
            {8'h3F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            {8'hE7, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // tree ends mid byte, skip the rest
            {8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // eight symbols per byte
            {8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            {8'h5A, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            {8'h50, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},  // three leaves: A=0, B=10, C=11
            {8'h54, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            {8'h2A, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            {8'h18, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            {8'hB7, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // ends inside a code
            {8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},  // code carried across bytes
            {8'hB7, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            {8'h3F, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},  // new stream drops the partial code
            {8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},  // restart in the middle of a header
            {8'h80, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            {8'h7F, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1},  // lone leaf, symbol 0x00
            {8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        restart_tree();

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        hold_off();

        // stack overflow: one internal node more than the stack holds, no idling
        steady = 1'b1;
        stream_bits.delete();
        repeat (N_STACK + 1)
            stream_bits.push_back(1'b0);
        send_bits(1'b1);
        send_plain(8'($urandom_range(0, 255)), 1'b0);
        steady = 1'b0;
        hold_off();

        base = sent_bytes - halted_bytes;
        while (sent_bytes - halted_bytes - base < RANDOM_BYTES) begin
            kind = $urandom_range(0, 9);
            stream_bits.delete();
            if (kind <= 6) begin
                // well-formed tree, then random code bits
                add_subtree(0, $urandom_range(1, 5));
                send_bits(1'b1);
                repeat ($urandom_range(1, 10))
                    send_plain(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind == 7) begin
                push_leaf(8'($urandom_range(0, 255)));
                send_bits(1'b1);
                repeat ($urandom_range(1, 2))
                    send_plain(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind == 8) begin
                // header cut short; the next stream restarts it
                add_subtree(0, 5);
                cut = $urandom_range(1, stream_bits.size() - 1);
                while (stream_bits.size() > cut)
                    void'(stream_bits.pop_back());
                send_bits(1'b1);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_plain(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end

        in_if.valid <= 1'b0;
        while (expected_syms.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("decoder run: %0d byte requests in %0d streams (%0d ignored while halted)",
                 sent_bytes, streams, halted_bytes);
        $display("decoder run: %0d results checked, %0d of them malformed-tree errors",
                 checked, errors_seen);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
